>>> rtl/lifo_stack_with_walk_top_assert.svh
// Assertion macros for the LIFO stack with walk
`ifndef LIFO_STACK_WITH_WALK_TOP_ASSERT_SVH
`define LIFO_STACK_WITH_WALK_TOP_ASSERT_SVH

// Plain property, checked on clk, muted while in reset
`define LSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication
`define LSW_ASSERT_IMPL(lbl, ante, cons, msg) \
  `LSW_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> rtl/lsw_pkg.sv
`timescale 1ns / 1ps

package lsw_pkg;

  // Default storage shape
  localparam int DEPTH_DEF = 64;
  localparam int WIDTH_DEF = 32;

  // Fixed field widths
  localparam int CNT_W  = 7;
  localparam int FUNC_W = 3;
  localparam int WPOS_W = 8;

  localparam logic [CNT_W-1:0] LEN_RST = 7'd64;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK_TOP = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PEEK_BOT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_WALK     = 3'd4;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAIT = 2'b10
  } lsw_state_t;

  // Memory strobes
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // Status held while the memory read completes
  typedef struct packed {
    logic             ok;
    logic             use_rd;
    logic             empty;
    logic             full;
    logic [CNT_W-1:0] count;
  } res_meta_t;

endpackage

>>> rtl/lsw_ram.sv
`timescale 1ns / 1ps

module lsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/lsw_ctrl.sv
`timescale 1ns / 1ps

module lsw_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [lsw_pkg::CNT_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  input  logic [lsw_pkg::FUNC_W-1:0]     in_func,
  output logic                           in_ready,
  input  logic                           out_free,
  output lsw_pkg::mem_ctl_t              mem_ctl,
  output logic [$clog2(DEPTH)-1:0]       mem_addr,
  output logic                           res_valid,
  output lsw_pkg::res_meta_t             res_meta
);
  import lsw_pkg::*;

  localparam int AW = $clog2(DEPTH);

  lsw_state_t          st_r, st_nxt;
  logic [CNT_W-1:0]    len_r;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [WPOS_W-1:0]   wpos_r, wpos_nxt;
  logic                wdown_r, wdown_nxt;
  res_meta_t           meta_r, meta_nxt;
  logic                acc;
  logic                op_ok;
  logic                op_rd;
  logic                op_wr;
  logic [CNT_W-1:0]    addr_cnt;
  logic                walk_hit;

  // Full when the count reaches the length or the physical depth
  function automatic logic is_full(input logic [CNT_W-1:0] f, input logic [CNT_W-1:0] l);
    is_full = (f >= l) || (32'(f) >= 32'(DEPTH));
  endfunction

  assign in_ready = (st_r == ST_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign walk_hit = !wpos_r[WPOS_W-1] && (wpos_r[WPOS_W-2:0] < fill_r);

  // Operation decode and next state
  always_comb begin
    fill_nxt  = fill_r;
    wpos_nxt  = wpos_r;
    wdown_nxt = wdown_r;
    op_ok     = 1'b0;
    op_rd     = 1'b0;
    op_wr     = 1'b0;
    addr_cnt  = '0;
    if (acc) begin
      unique case (in_func)
        FN_PUSH: begin
          addr_cnt = fill_r;
          if (!is_full(fill_r, len_r)) begin
            op_wr    = 1'b1;
            op_ok    = 1'b1;
            fill_nxt = fill_r + 7'd1;
          end
        end
        FN_POP: begin
          addr_cnt = fill_r - 7'd1;
          if (fill_r != '0) begin
            op_rd    = 1'b1;
            op_ok    = 1'b1;
            fill_nxt = fill_r - 7'd1;
          end
        end
        FN_PEEK_TOP: begin
          addr_cnt  = fill_r - 7'd1;
          wdown_nxt = 1'b1;
          wpos_nxt  = {1'b0, fill_r} - 8'd2;
          if (fill_r != '0) begin
            op_rd = 1'b1;
            op_ok = 1'b1;
          end
        end
        FN_PEEK_BOT: begin
          wdown_nxt = 1'b0;
          wpos_nxt  = 8'd1;
          if (fill_r != '0) begin
            op_rd = 1'b1;
            op_ok = 1'b1;
          end
        end
        FN_WALK: begin
          addr_cnt = wpos_r[WPOS_W-2:0];
          if (walk_hit) begin
            op_rd    = 1'b1;
            op_ok    = 1'b1;
            wpos_nxt = wdown_r ? (wpos_r - 8'd1) : (wpos_r + 8'd1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_ctl.we = op_wr;
  assign mem_ctl.re = op_rd;
  assign mem_addr   = AW'(addr_cnt);

  // Result status, from the state after the operation
  always_comb begin
    meta_nxt.ok     = op_ok;
    meta_nxt.use_rd = op_rd;
    meta_nxt.empty  = (fill_nxt == '0);
    meta_nxt.full   = is_full(fill_nxt, len_r);
    meta_nxt.count  = fill_nxt;
  end

  // Two-state sequencer: accept, then wait for read data
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (acc) st_nxt = ST_WAIT;
      ST_WAIT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign res_valid = (st_r == ST_WAIT);
  assign res_meta  = meta_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      len_r   <= LEN_RST;
      fill_r  <= '0;
      wpos_r  <= '1;
      wdown_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      fill_r  <= fill_nxt;
      wpos_r  <= wpos_nxt;
      wdown_r <= wdown_nxt;
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
    end
  end

  // Status payload
  always_ff @(posedge clk) begin
    if (acc) begin
      meta_r <= meta_nxt;
    end
  end

endmodule

>>> rtl/lifo_stack_with_walk_top.sv
`timescale 1ns / 1ps

// LIFO stack with a bidirectional walk. Each input beat carries one operation
// (push, pop, peek top, peek bottom, walk next) and yields exactly one result
// beat. The block takes no new beat while a memory read is in flight: the
// stack entries sit in a single-port memory with a registered read, so each
// operation has a memory access step followed by a read return step. A
// result is captured in an output register once the read data returns and is
// held there while stalled, so a new input beat is taken in the same cycle the
// previous result is consumed. The entry memory needs no clearing after reset;
// only entries below the fill count are ever read. The length register may be
// written at any time the block is idle; writing it below the current count
// only blocks pushes.
module lifo_stack_with_walk_top #(
  parameter int DEPTH = lsw_pkg::DEPTH_DEF,
  parameter int WIDTH = lsw_pkg::WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           cfg_wr_en,
  input  logic [lsw_pkg::CNT_W-1:0]                      cfg_wr_data,
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  // push_data, zero padded to bytes
  input  logic [((WIDTH+7)/8)*8-1:0]                     in_tdata,
  // func
  input  logic [lsw_pkg::FUNC_W-1:0]                     in_tuser,
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // out_data, empty_res, full_res, count, zero padded to bytes
  output logic [((WIDTH+2+lsw_pkg::CNT_W+7)/8)*8-1:0]    out_tdata,
  // ok
  output logic                                           out_tuser
);
  import lsw_pkg::*;

  localparam int OUT_TD_W = ((WIDTH + 2 + CNT_W + 7) / 8) * 8;

  mem_ctl_t                 mem_ctl;
  logic [$clog2(DEPTH)-1:0] mem_addr;
  logic [WIDTH-1:0]         mem_rdata;
  logic                     res_valid;
  res_meta_t                res_meta;
  logic                     out_free;

  logic                     out_valid_r;
  logic                     out_ok_r;
  logic [WIDTH-1:0]         out_data_r;
  logic                     out_empty_r;
  logic                     out_full_r;
  logic [CNT_W-1:0]         out_cnt_r;

  assign out_free = !out_valid_r || out_tready;

  lsw_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_tvalid),
    .in_func    (in_tuser),
    .in_ready   (in_tready),
    .out_free   (out_free),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .res_valid  (res_valid),
    .res_meta   (res_meta)
  );

  lsw_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_ctl.we),
    .re   (mem_ctl.re),
    .addr (mem_addr),
    .wdata(in_tdata[WIDTH-1:0]),
    .rdata(mem_rdata)
  );

  // Output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output beat payload; data reads as zero unless the memory was read
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_ok_r    <= res_meta.ok;
      out_data_r  <= res_meta.use_rd ? mem_rdata : '0;
      out_empty_r <= res_meta.empty;
      out_full_r  <= res_meta.full;
      out_cnt_r   <= res_meta.count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = OUT_TD_W'({out_cnt_r, out_full_r, out_empty_r, out_data_r});

endmodule

>>> rtl/lsw_checker.sv
`timescale 1ns / 1ps

`include "lifo_stack_with_walk_top_assert.svh"

module lsw_checker #(
  parameter int DEPTH = lsw_pkg::DEPTH_DEF,
  parameter int WIDTH = lsw_pkg::WIDTH_DEF
) (
  input logic                                        clk,
  input logic                                        rst_n,
  input logic                                        in_tvalid,
  input logic                                        in_tready,
  input logic                                        out_tvalid,
  input logic                                        out_tready,
  input logic [((WIDTH+2+lsw_pkg::CNT_W+7)/8)*8-1:0] out_tdata,
  input logic                                        out_tuser
);
  import lsw_pkg::*;

  logic             in_acc;
  logic [CNT_W-1:0] cnt;

  assign in_acc = in_tvalid && in_tready;
  assign cnt    = out_tdata[WIDTH+2 +: CNT_W];

  // Stalled result beat holds
  `LSW_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "result beat changed while stalled")
  // Every accepted beat is followed by a valid result beat
  `LSW_ASSERT(a_result_lat, in_acc |-> ##2 out_tvalid, "result missing two cycles after accept")
  // No second beat while the memory read is in flight
  `LSW_ASSERT(a_interlock, in_acc |=> !in_tready, "input taken during memory read")
  // Empty flag matches the count
  `LSW_ASSERT_IMPL(a_empty_cnt, out_tvalid, out_tdata[WIDTH] == (cnt == '0), "empty flag disagrees with count")
  // Count never exceeds the storage depth
  `LSW_ASSERT_IMPL(a_cnt_max, out_tvalid, 32'(cnt) <= 32'(DEPTH), "count above depth")

endmodule

bind lifo_stack_with_walk_top lsw_checker #(
  .DEPTH(DEPTH),
  .WIDTH(WIDTH)
) u_lsw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

>>> tb/lifo_stack_with_walk_top_test.sv
`timescale 1ns / 1ps

module lifo_stack_with_walk_top_test;
  import lsw_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int WIDTH       = WIDTH_DEF;
  localparam int IN_W        = ((WIDTH + 7) / 8) * 8;
  localparam int OUT_W       = ((WIDTH + 2 + CNT_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 500;
  localparam int SETTLE_CYC  = 4;
  localparam int RAND_ITEMS  = 1600;
  localparam int QUIET_TAIL  = 200;
  localparam int TAIL_CYC    = 8;
  localparam int PRINT_MAX   = 40;

  // What a queued stimulus entry asks the driver to do
  typedef enum logic [1:0] {
    BT_OP,
    BT_CFG,
    BT_DRAIN
  } beat_kind_t;

  typedef struct {
    beat_kind_t        kind;
    logic [FUNC_W-1:0] func;
    logic [WIDTH-1:0]  data;
    logic [CNT_W-1:0]  len;
    int                idle;
  } stim_t;

  typedef struct {
    logic             ok;
    logic [WIDTH-1:0] data;
    logic             empty;
    logic             full;
    logic [CNT_W-1:0] count;
  } stack_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // push_data
  logic [IN_W-1:0]  in_tdata = '0;
  // func
  logic [FUNC_W-1:0] in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // out_data, empty_res, full_res, count
  logic [OUT_W-1:0] out_tdata;
  // ok
  logic             out_tuser;

  lifo_stack_with_walk_top #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Stimulus, expected results and shadow stack state
  stim_t            stim_q[$];
  stack_res_t       pending_res_q[$];
  int               build_idle = 0;
  int               made = 0;
  int               err_cnt = 0;

  logic [WIDTH-1:0] stack_mem [DEPTH];
  int               stack_fill = 0;
  int               walk_at = -1;
  bit               walk_dn = 1'b0;
  logic [CNT_W-1:0] cap_len = LEN_RST;

  bit               in_beat_seen = 1'b0;
  int               quiet_cyc = 0;
  int               snd_gap = 0;
  int               rcv_stall = 0;
  int               settle = 0;
  int               cur_idle = 0;

  task automatic note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= PRINT_MAX) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // Apply one operation to the shadow stack, return the result it must give
  function automatic stack_res_t stack_predict(input logic [FUNC_W-1:0] fn,
                                               input logic [WIDTH-1:0] d);
    stack_res_t r;
    int lim;
    lim = (cap_len > DEPTH) ? DEPTH : int'(cap_len);
    r.ok = 1'b0;
    r.data = '0;
    case (fn)
      FN_PUSH: begin
        if (stack_fill < lim) begin
          stack_mem[stack_fill] = d;
          stack_fill++;
          r.ok = 1'b1;
        end
      end
      FN_POP: begin
        if (stack_fill > 0) begin
          stack_fill--;
          r.data = stack_mem[stack_fill];
          r.ok = 1'b1;
        end
      end
      // peek top also arms a downward walk starting below the top
      FN_PEEK_TOP: begin
        walk_dn = 1'b1;
        walk_at = stack_fill - 2;
        if (stack_fill > 0) begin
          r.data = stack_mem[stack_fill-1];
          r.ok = 1'b1;
        end
      end
      // peek bottom arms an upward walk starting above the bottom
      FN_PEEK_BOT: begin
        walk_dn = 1'b0;
        walk_at = 1;
        if (stack_fill > 0) begin
          r.data = stack_mem[0];
          r.ok = 1'b1;
        end
      end
      // walk position is checked against the live count, never adjusted
      FN_WALK: begin
        if (walk_at >= 0 && walk_at < stack_fill) begin
          r.data = stack_mem[walk_at];
          walk_at = walk_dn ? walk_at - 1 : walk_at + 1;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.empty = (stack_fill == 0);
    r.full  = (stack_fill >= lim);
    r.count = stack_fill[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [WIDTH-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // ops near the end of the plan carry no idling
  task automatic queue_op(input logic [FUNC_W-1:0] fn, input logic [WIDTH-1:0] d);
    stim_t b;
    b.kind = BT_OP;
    b.func = fn;
    b.data = d;
    b.len  = '0;
    b.idle = (RAND_ITEMS - made <= QUIET_TAIL) ? 0 : build_idle;
    stim_q.push_back(b);
  endtask

  task automatic queue_ctl(input beat_kind_t kind, input logic [CNT_W-1:0] len);
    stim_t b;
    b.kind = kind;
    b.func = FN_PUSH;
    b.data = '0;
    b.len  = len;
    b.idle = build_idle;
    stim_q.push_back(b);
  endtask

  // Driver: input beats, config writes and result backpressure
  always @(negedge clk) begin
    stim_t b;
    logic nv;
    logic cfg_en_n;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      cfg_wr_en  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      nv = in_tvalid && !in_beat_seen;
      cfg_en_n = 1'b0;
      if (!nv) begin
        if (snd_gap > 0) begin
          snd_gap--;
        end else if (stim_q.size() > 0) begin
          b = stim_q[0];
          if (b.kind == BT_OP) begin
            void'(stim_q.pop_front());
            cur_idle = b.idle;
            nv = 1'b1;
            in_tuser <= b.func;
            in_tdata <= IN_W'(b.data);
            if (b.idle > 0 && $urandom_range(0, (16 >> b.idle) - 1) == 0) begin
              snd_gap = $urandom_range(1, 16);
            end
          end else if (pending_res_q.size() != 0) begin
            settle = 0;
          end else if (settle < SETTLE_CYC) begin
            // let the pipeline go quiet before touching the register
            settle++;
          end else begin
            void'(stim_q.pop_front());
            settle = 0;
            if (b.kind == BT_CFG) begin
              cfg_en_n = 1'b1;
              cfg_wr_data <= b.len;
            end
          end
        end
      end
      in_tvalid <= nv;
      cfg_wr_en <= cfg_en_n;

      // receiver stalls in bursts
      if (rcv_stall > 0) begin
        rcv_stall--;
        out_tready <= 1'b0;
      end else if (cur_idle > 0 && $urandom_range(0, (16 >> cur_idle) - 1) == 0) begin
        rcv_stall = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input beats, check result beats, watchdog
  always @(posedge clk) begin
    stack_res_t got;
    stack_res_t want;
    in_beat_seen = in_tvalid && in_tready;
    if (!rst_n) begin
      stack_fill = 0;
      walk_at = -1;
      walk_dn = 1'b0;
      cap_len = LEN_RST;
      quiet_cyc = 0;
    end else begin
      if (cfg_wr_en) begin
        cap_len = cfg_wr_data;
      end
      if (in_beat_seen) begin
        pending_res_q.push_back(stack_predict(in_tuser, in_tdata[WIDTH-1:0]));
      end
      if (out_tvalid && out_tready) begin
        got.ok    = out_tuser;
        got.data  = out_tdata[WIDTH-1:0];
        got.empty = out_tdata[WIDTH];
        got.full  = out_tdata[WIDTH+1];
        got.count = out_tdata[WIDTH+2 +: CNT_W];
        if (pending_res_q.size() == 0) begin
          note_mismatch($sformatf("result beat with nothing pending: ok %0b data %h count %0d",
                                  got.ok, got.data, got.count));
        end else begin
          want = pending_res_q.pop_front();
          if (got.ok !== want.ok || got.data !== want.data || got.empty !== want.empty ||
              got.full !== want.full || got.count !== want.count ||
              (out_tdata >> (WIDTH + 2 + CNT_W)) !== '0) begin
            note_mismatch($sformatf(
              "got/exp ok %0b/%0b data %h/%h empty %0b/%0b full %0b/%0b count %0d/%0d pad %0h",
              got.ok, want.ok, got.data, want.data, got.empty, want.empty,
              got.full, want.full, got.count, want.count,
              out_tdata >> (WIDTH + 2 + CNT_W)));
          end
        end
      end
      if (in_beat_seen || (out_tvalid && out_tready) || cfg_wr_en) begin
        quiet_cyc = 0;
      end else begin
        quiet_cyc++;
        if (quiet_cyc >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Stimulus plan, reset and end of run
  initial begin
    logic [CNT_W-1:0] phase_len [8];
    logic [CNT_W-1:0] len;
    logic [FUNC_W-1:0] fn;
    int phase;
    int nops;
    int pick;
    int wlen;
    bit push_trend;

    phase_len = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd2, 7'd65, 7'd64, 7'd3};

    // empty stack: every read fails, walk starts out invalid
    build_idle = 0;
    queue_op(FN_WALK, rand_word());
    queue_op(FN_POP, rand_word());
    queue_op(FN_PEEK_TOP, rand_word());
    queue_op(FN_PEEK_BOT, rand_word());
    queue_op(FN_PUSH, '0);
    queue_op(FN_PUSH, '1);
    queue_op(FN_PUSH, 32'hA5A5_5A5A);
    // walk down from the top until it runs off the bottom
    queue_op(FN_PEEK_TOP, '0);
    repeat (3) queue_op(FN_WALK, '1);
    queue_op(FN_WALK, '0);
    // walk up from the bottom until it runs off the top
    queue_op(FN_PEEK_BOT, '1);
    repeat (3) queue_op(FN_WALK, '0);
    // unused operation codes
    queue_op(3'd5, '1);
    queue_op(3'd6, '0);
    queue_op(3'd7, '1);
    repeat (4) queue_op(FN_POP, '0);

    made = 0;
    phase = 0;
    push_trend = 1'b0;
    while (made < RAND_ITEMS) begin
      len = (phase < 8) ? phase_len[phase] : CNT_W'($urandom_range(0, 127));
      queue_ctl(BT_CFG, len);
      repeat ($urandom_range(2, 4)) begin
        build_idle = (RAND_ITEMS - made <= QUIET_TAIL) ? 0 : $urandom_range(0, 3);
        push_trend = ~push_trend;
        // open with a run that drives toward full or toward empty
        repeat ($urandom_range(0, 70)) begin
          if (made < RAND_ITEMS) begin
            queue_op(push_trend ? FN_PUSH : FN_POP, rand_word());
            made++;
          end
        end
        nops = $urandom_range(20, 140);
        for (int i = 0; i < nops && made < RAND_ITEMS; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 2) fn = FUNC_W'($urandom_range(5, 7));
          else if (pick < 7) fn = FN_PEEK_TOP;
          else if (pick < 12) fn = FN_PEEK_BOT;
          else if (pick < 30) fn = FN_WALK;
          else if (pick < 90) fn = push_trend ? FN_PUSH : FN_POP;
          else fn = push_trend ? FN_POP : FN_PUSH;
          queue_op(fn, rand_word());
          made++;
          // a peek is usually followed by a walk, now and then a full sweep
          if (fn == FN_PEEK_TOP || fn == FN_PEEK_BOT) begin
            wlen = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70)
                                                : $urandom_range(1, 8);
            repeat (wlen) begin
              if (made < RAND_ITEMS) begin
                queue_op(FN_WALK, rand_word());
                made++;
              end
            end
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          queue_ctl(BT_DRAIN, '0);
        end
      end
      phase++;
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_tvalid || pending_res_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYC) @(posedge clk);

    if (err_cnt == 0 && pending_res_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
